// ===== src/best_fit_resource_allocator_top_defines.svh =====
// Assertion macros for the best-fit allocator.
// Each expects clk_i and rst_ni in the scope of the using module.
`ifndef BEST_FIT_RESOURCE_ALLOCATOR_TOP_DEFINES_SVH
`define BEST_FIT_RESOURCE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define BFRA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bfra: same-cycle check failed");

// Next-cycle implication.
`define BFRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bfra: next-cycle check failed");

`endif

// ===== src/bfra_pkg.sv =====
package bfra_pkg;

  localparam int MaxResources = 10;
  localparam int CapacityBits = 16;
  localparam int SlotW        = 16;
  localparam int SlotsPerWord = 4;
  localparam int MapW         = MaxResources + 1;
  localparam int IdxW         = $clog2(MapW);
  localparam int CapIdxW      = $clog2(MaxResources);
  localparam int CountW       = 4;
  localparam int WeightW      = 16;
  localparam int RelIdxW      = 4;
  localparam int GrantW       = 4;
  localparam int IdW          = 16;
  localparam int StatusW      = 2;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 64;
  localparam int BackupReset  = 15000;
  localparam int CountReset   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COUNT    = 3'd0,
    CFG_CAP_LOW  = 3'd1,
    CFG_CAP_MID  = 3'd2,
    CFG_CAP_HIGH = 3'd3,
    CFG_BACKUP   = 3'd4
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_GRANTED  = 2'd0,
    STATUS_NONE     = 2'd1,
    STATUS_RELEASED = 2'd2
  } status_e;

  typedef enum logic {
    REQ_CLAIM   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic               start;
    logic [WeightW-1:0] weight;
  } scan_cmd_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] index;
  } scan_res_t;

  typedef struct packed {
    logic      busy;
    logic      done;
    scan_res_t res;
  } scan_stat_t;

endpackage

// ===== src/bfra_req_if.sv =====
interface bfra_req_if;
  import bfra_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [WeightW-1:0] weight;
  logic [RelIdxW-1:0] release_index;
  logic [IdW-1:0]     client_id;

  modport source (output valid, req_type, weight, release_index, client_id, input ready);
  modport sink   (input valid, req_type, weight, release_index, client_id, output ready);
endinterface

// ===== src/bfra_rsp_if.sv =====
interface bfra_rsp_if;
  import bfra_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [GrantW-1:0]  grant_index;
  logic [IdW-1:0]     echo_id;

  modport source (output valid, status, grant_index, echo_id, input ready);
  modport sink   (input valid, status, grant_index, echo_id, output ready);
endinterface

// ===== src/bfra_cfg_if.sv =====
interface bfra_cfg_if;
  import bfra_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/bfra_cfg_regs.sv =====
module bfra_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bfra_cfg_if.sink                        cfg_i,
  input  logic [bfra_pkg::IdxW-1:0]       entry_idx_i,
  output logic [bfra_pkg::CapacityBits-1:0] entry_cap_o,
  output logic [bfra_pkg::CapacityBits-1:0] threshold_o,
  output logic [bfra_pkg::IdxW-1:0]       count_o
);
  import bfra_pkg::*;

  logic [CountW-1:0]       count_q, count_d;
  logic [CapacityBits-1:0] caps_q [MaxResources];
  logic [CapacityBits-1:0] caps_d [MaxResources];
  logic [CapacityBits-1:0] backup_q, backup_d;
  logic                    wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;

  always_comb begin
    count_d  = count_q;
    backup_d = backup_q;
    caps_d   = caps_q;
    if (wr) begin
      case (cfg_i.index)
        CFG_COUNT:  count_d  = cfg_i.data[CountW-1:0];
        CFG_BACKUP: backup_d = cfg_i.data[CapacityBits-1:0];
        default: ;
      endcase
      // each capacity word holds four 16-bit slots
      for (int k = 0; k < MaxResources; k++) begin
        if (cfg_i.index == CfgIdxW'(CFG_CAP_LOW) + CfgIdxW'(k / SlotsPerWord)) begin
          caps_d[k] = cfg_i.data[(k % SlotsPerWord)*SlotW +: CapacityBits];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= CountW'(CountReset);
      backup_q <= CapacityBits'(BackupReset);
      for (int k = 0; k < MaxResources; k++) begin
        caps_q[k] <= '0;
      end
    end else begin
      count_q  <= count_d;
      backup_q <= backup_d;
      caps_q   <= caps_d;
    end
  end

  // clamp the count to the number of physical slots
  assign count_o = (count_q > CountW'(MaxResources)) ? IdxW'(MaxResources) : IdxW'(count_q);

  assign threshold_o = backup_q;

  always_comb begin
    if (entry_idx_i == count_o) begin
      entry_cap_o = backup_q;
    end else if (entry_idx_i < IdxW'(MaxResources)) begin
      entry_cap_o = caps_q[entry_idx_i[CapIdxW-1:0]];
    end else begin
      entry_cap_o = '0;
    end
  end

endmodule

// ===== src/bfra_scan.sv =====
module bfra_scan (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bfra_pkg::scan_cmd_t               cmd_i,
  input  logic [bfra_pkg::IdxW-1:0]         count_i,
  input  logic [bfra_pkg::MapW-1:0]         busy_map_i,
  input  logic [bfra_pkg::CapacityBits-1:0] entry_cap_i,
  input  logic [bfra_pkg::CapacityBits-1:0] threshold_i,
  output logic [bfra_pkg::IdxW-1:0]         entry_idx_o,
  output bfra_pkg::scan_stat_t              stat_o
);
  import bfra_pkg::*;

  logic                    run_q, run_d;
  logic                    done_q, done_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [WeightW-1:0]      weight_q, weight_d;
  logic                    fit_found_q, fit_found_d;
  logic [IdxW-1:0]         fit_idx_q, fit_idx_d;
  logic [CapacityBits-1:0] fit_cap_q, fit_cap_d;
  logic                    fb_found_q, fb_found_d;
  logic [IdxW-1:0]         fb_idx_q, fb_idx_d;
  scan_res_t               res_q, res_d;

  logic free, fit_hit, fb_hit, last;

  assign free    = !busy_map_i[idx_q];
  assign fit_hit = run_q && free && (WeightW'(entry_cap_i) >= weight_q)
                   && (!fit_found_q || (entry_cap_i < fit_cap_q));
  assign fb_hit  = run_q && free && (entry_cap_i >= threshold_i) && !fb_found_q;
  assign last    = run_q && (idx_q == count_i);

  always_comb begin
    run_d       = run_q;
    idx_d       = idx_q;
    weight_d    = weight_q;
    fit_found_d = fit_found_q | fit_hit;
    fit_idx_d   = fit_hit ? idx_q : fit_idx_q;
    fit_cap_d   = fit_hit ? entry_cap_i : fit_cap_q;
    fb_found_d  = fb_found_q | fb_hit;
    fb_idx_d    = fb_hit ? idx_q : fb_idx_q;
    done_d      = last;
    res_d       = res_q;

    if (last) begin
      run_d       = 1'b0;
      res_d.found = fit_found_d | fb_found_d;
      if (fit_found_d) begin
        res_d.index = fit_idx_d;
      end else if (fb_found_d) begin
        res_d.index = fb_idx_d;
      end else begin
        res_d.index = '0;
      end
    end else if (run_q) begin
      idx_d = idx_q + IdxW'(1);
    end

    // start a fresh pass from entry zero
    if (cmd_i.start) begin
      run_d       = 1'b1;
      idx_d       = '0;
      weight_d    = cmd_i.weight;
      fit_found_d = 1'b0;
      fb_found_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      done_q      <= 1'b0;
      idx_q       <= '0;
      fit_found_q <= 1'b0;
      fb_found_q  <= 1'b0;
    end else begin
      run_q       <= run_d;
      done_q      <= done_d;
      idx_q       <= idx_d;
      fit_found_q <= fit_found_d;
      fb_found_q  <= fb_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    weight_q  <= weight_d;
    fit_idx_q <= fit_idx_d;
    fit_cap_q <= fit_cap_d;
    fb_idx_q  <= fb_idx_d;
    res_q     <= res_d;
  end

  assign entry_idx_o = idx_q;
  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign stat_o.res  = res_q;

endmodule

// ===== src/best_fit_resource_allocator_top.sv =====
// Best-fit resource allocator. A claim transaction gets the free entry of least capacity
// that still carries its weight (lowest index on ties), else the first free entry whose
// capacity reaches the backup capacity, else status "no free resource" with index 0; the
// granted entry is marked busy. A release transaction frees one entry in the active range
// (count clamped to 10, the backup entry sits at index count). One comparator visits one
// entry per cycle, so a claim occupies the block for one pass over entries 0 to n (n =
// active count, at most 10); the request side is not ready until a result is loaded. The
// result sits in an output register, and a new transaction is taken while it waits.
// Configuration writes are always ready and take effect on the next cycle; write them only
// when idle.
`include "best_fit_resource_allocator_top_defines.svh"

module best_fit_resource_allocator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfra_req_if.sink   req_i,
  bfra_rsp_if.source rsp_o,
  bfra_cfg_if.sink   cfg_i
);
  import bfra_pkg::*;

  state_e                  state_q, state_d;
  logic [MapW-1:0]         busy_map_q, busy_map_d;
  status_e                 pend_status_q, pend_status_d;
  logic [GrantW-1:0]       pend_index_q, pend_index_d;
  logic [IdW-1:0]          pend_id_q, pend_id_d;
  logic                    out_valid_q, out_valid_d;
  status_e                 out_status_q;
  logic [GrantW-1:0]       out_index_q;
  logic [IdW-1:0]          out_id_q;
  logic                    out_load;
  logic                    in_acc;
  logic [IdxW-1:0]         count;
  logic [IdxW-1:0]         entry_idx;
  logic [CapacityBits-1:0] entry_cap;
  logic [CapacityBits-1:0] threshold;
  scan_cmd_t               scan_cmd;
  scan_stat_t              scan_stat;

  bfra_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .entry_idx_i (entry_idx),
    .entry_cap_o (entry_cap),
    .threshold_o (threshold),
    .count_o     (count)
  );

  bfra_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (scan_cmd),
    .count_i     (count),
    .busy_map_i  (busy_map_q),
    .entry_cap_i (entry_cap),
    .threshold_i (threshold),
    .entry_idx_o (entry_idx),
    .stat_o      (scan_stat)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;

  always_comb begin
    state_d         = state_q;
    busy_map_d      = busy_map_q;
    pend_status_d   = pend_status_q;
    pend_index_d    = pend_index_q;
    pend_id_d       = pend_id_q;
    scan_cmd.start  = 1'b0;
    scan_cmd.weight = req_i.weight;
    out_load        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pend_id_d = req_i.client_id;
          if (req_i.req_type == REQ_RELEASE) begin
            pend_status_d = STATUS_RELEASED;
            pend_index_d  = GrantW'(req_i.release_index);
            // out-of-range release leaves the map alone
            if (32'(req_i.release_index) <= 32'(count)) begin
              busy_map_d = busy_map_q & ~(MapW'(1) << req_i.release_index);
            end
            state_d = ST_HOLD;
          end else begin
            scan_cmd.start = 1'b1;
            state_d        = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          if (scan_stat.res.found) begin
            pend_status_d = STATUS_GRANTED;
            pend_index_d  = GrantW'(scan_stat.res.index);
            busy_map_d    = busy_map_q | (MapW'(1) << scan_stat.res.index);
          end else begin
            pend_status_d = STATUS_NONE;
            pend_index_d  = '0;
          end
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // move the result once the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      busy_map_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_map_q  <= busy_map_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_index_q  <= pend_index_d;
    pend_id_q     <= pend_id_d;
    if (out_load) begin
      out_status_q <= pend_status_q;
      out_index_q  <= pend_index_q;
      out_id_q     <= pend_id_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.grant_index = out_index_q;
  assign rsp_o.echo_id     = out_id_q;

  `BFRA_ASSERT_IMPL(a_scan_blocks_req, scan_stat.busy, !req_i.ready)
  `BFRA_ASSERT_NEXT(a_grant_marks_busy, (state_q == ST_SCAN) && scan_stat.done && scan_stat.res.found, busy_map_q[$past(scan_stat.res.index)])
  `BFRA_ASSERT_NEXT(a_release_frees, in_acc && (req_i.req_type == REQ_RELEASE) && (req_i.release_index <= count), !busy_map_q[$past(req_i.release_index)])
  `BFRA_ASSERT_IMPL(a_none_index_zero, rsp_o.valid && (out_status_q == STATUS_NONE), out_index_q == '0)

endmodule
